### hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and bit functions of the SHA-256 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned WordCount   = 8;
	localparam int unsigned WindowDepth = 16;

	localparam logic       KindData   = 1'b0;
	localparam logic       KindFinish = 1'b1;

	localparam logic [7:0] PadMarker  = 8'h80;
	localparam logic [5:0] FillLast   = 6'd63;
	localparam logic [5:0] FillLenPos = 6'd56;
	localparam logic [5:0] FillPadMax = 6'd55;
	localparam logic [5:0] RoundLast  = 6'd63;
	localparam logic [2:0] WordLast   = 3'd7;

	localparam word_t InitWords [0:WordCount-1] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       word_done;
		logic [7:0] byte_val;
		logic       step;
	} sched_ctrl_t;

	typedef struct packed {
		logic       start;
		logic       step;
		logic       fold;
		logic       reinit;
		logic [5:0] rnd;
	} rnd_ctrl_t;

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

`default_nettype wire

### hw/rtl/sha256_sched.sv
// ----------------------------------------------------------------------------
// sha256_sched
// Message schedule: packs bytes into big-endian words, holds a sliding
// window of sixteen words and expands one new word per round.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_sched (
	input  wire                     clk,
	input  sha256_pkg::sched_ctrl_t ctrl,
	output sha256_pkg::word_t       w_cur
);

	logic [23:0]       acc_q;
	sha256_pkg::word_t win_q [0:sha256_pkg::WindowDepth-1];
	sha256_pkg::word_t w_next;

	assign w_cur  = win_q[0];
	assign w_next = sha256_pkg::small_sigma1(win_q[14]) + win_q[9]
		+ sha256_pkg::small_sigma0(win_q[1]) + win_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= {acc_q[15:0], ctrl.byte_val};
		end
		if ((ctrl.load && ctrl.word_done) || ctrl.step) begin
			for (int i = 0; i < sha256_pkg::WindowDepth - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			// new word enters at the tail: packed bytes on load, expansion on a round
			win_q[sha256_pkg::WindowDepth-1] <= ctrl.step ? w_next : {acc_q, ctrl.byte_val};
		end
	end

endmodule

`default_nettype wire

### hw/rtl/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// Compression round unit: one round per cycle on the working variables,
// plus the chaining hash words and their fold after the last round.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_round (
	input  wire                     clk,
	input  wire                     arst_n,
	input  sha256_pkg::rnd_ctrl_t   ctrl,
	input  sha256_pkg::word_t       w_cur,
	input  wire [2:0]               sel,
	output sha256_pkg::word_t       hash_word
);

	sha256_pkg::word_t hash_q [0:sha256_pkg::WordCount-1];
	sha256_pkg::word_t v_q    [0:sha256_pkg::WordCount-1];
	sha256_pkg::word_t ch;
	sha256_pkg::word_t maj;
	sha256_pkg::word_t t1;
	sha256_pkg::word_t t2;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + sha256_pkg::big_sigma1(v_q[4]) + ch
		+ sha256_pkg::RoundK[ctrl.rnd] + w_cur;
	assign t2  = sha256_pkg::big_sigma0(v_q[0]) + maj;

	assign hash_word = hash_q[sel];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha256_pkg::WordCount; i++) begin
				hash_q[i] <= sha256_pkg::InitWords[i];
			end
		end else if (ctrl.reinit) begin
			for (int i = 0; i < sha256_pkg::WordCount; i++) begin
				hash_q[i] <= sha256_pkg::InitWords[i];
			end
		end else if (ctrl.fold) begin
			for (int i = 0; i < sha256_pkg::WordCount; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			for (int i = 0; i < sha256_pkg::WordCount; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (ctrl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/sha256_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit
// SHA-256 over a byte stream: byte loading, padding sequencer, one shared
// round unit and a word-serial digest output.
// ----------------------------------------------------------------------------
// Data byte: taken while idle; the 64th byte of a block starts the rounds
//   and then the fold, all through the single round unit.
// Finish: pad bytes up to the block end, a compression each time (one or
//   two), then eight digest words, one per cycle while digest_ready is high.
// Reset: hash words load the initial values, counters clear, block idle.
`default_nettype none

module sha256_hash_engine_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         req_valid,
	output logic        req_ready,
	input  wire         kind,
	input  wire  [7:0]  data_byte,
	output logic        digest_valid,
	input  wire         digest_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);

	sha256_pkg::state_t      state_q;
	sha256_pkg::state_t      state_d;
	sha256_pkg::sched_ctrl_t sc;
	sha256_pkg::rnd_ctrl_t   rc;
	sha256_pkg::word_t       w_cur;

	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        pad_q;
	logic        pad_first_q;
	logic        len_ok_q;
	logic        final_q;
	logic [63:0] total_bits;
	logic [7:0]  len_byte;
	logic [7:0]  pad_byte;
	logic        take_req;

	assign take_req   = req_valid && req_ready;
	assign total_bits = {count_q, 3'b000};

	always_comb begin
		case (fill_q[2:0])
			3'd0:    len_byte = total_bits[63:56];
			3'd1:    len_byte = total_bits[55:48];
			3'd2:    len_byte = total_bits[47:40];
			3'd3:    len_byte = total_bits[39:32];
			3'd4:    len_byte = total_bits[31:24];
			3'd5:    len_byte = total_bits[23:16];
			3'd6:    len_byte = total_bits[15:8];
			default: len_byte = total_bits[7:0];
		endcase
	end

	always_comb begin
		if (pad_first_q) begin
			pad_byte = sha256_pkg::PadMarker;
		end else if (len_ok_q && fill_q >= sha256_pkg::FillLenPos) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (kind == sha256_pkg::KindFinish) begin
						state_d = sha256_pkg::ST_PAD;
					end else if (fill_q == sha256_pkg::FillLast) begin
						state_d = sha256_pkg::ST_COMP;
					end
				end
			end
			sha256_pkg::ST_PAD: begin
				if (fill_q == sha256_pkg::FillLast) begin
					state_d = sha256_pkg::ST_COMP;
				end
			end
			sha256_pkg::ST_COMP: begin
				if (rnd_q == sha256_pkg::RoundLast) begin
					state_d = sha256_pkg::ST_FOLD;
				end
			end
			sha256_pkg::ST_FOLD: begin
				if (!pad_q) begin
					state_d = sha256_pkg::ST_IDLE;
				end else if (final_q) begin
					state_d = sha256_pkg::ST_OUT;
				end else begin
					state_d = sha256_pkg::ST_PAD;
				end
			end
			sha256_pkg::ST_OUT: begin
				if (digest_ready && idx_q == sha256_pkg::WordLast) begin
					state_d = sha256_pkg::ST_IDLE;
				end
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	// outputs and unit controls
	always_comb begin
		req_ready    = (state_q == sha256_pkg::ST_IDLE);
		digest_valid = (state_q == sha256_pkg::ST_OUT);
		sc.load      = (state_q == sha256_pkg::ST_PAD)
			|| (take_req && kind == sha256_pkg::KindData);
		sc.byte_val  = (state_q == sha256_pkg::ST_PAD) ? pad_byte : data_byte;
		sc.word_done = (fill_q[1:0] == 2'b11);
		sc.step      = (state_q == sha256_pkg::ST_COMP);
		rc.start     = sc.load && fill_q == sha256_pkg::FillLast;
		rc.step      = (state_q == sha256_pkg::ST_COMP);
		rc.fold      = (state_q == sha256_pkg::ST_FOLD);
		rc.reinit    = digest_valid && digest_ready && idx_q == sha256_pkg::WordLast;
		rc.rnd       = rnd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha256_pkg::ST_IDLE;
			fill_q      <= '0;
			count_q     <= '0;
			rnd_q       <= '0;
			idx_q       <= '0;
			pad_q       <= 1'b0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
			final_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sc.load) begin
				fill_q <= fill_q + 6'd1;
			end
			if (take_req && kind == sha256_pkg::KindData) begin
				count_q <= count_q + 61'd1;
			end
			if (take_req && kind == sha256_pkg::KindFinish) begin
				pad_q       <= 1'b1;
				pad_first_q <= 1'b1;
				len_ok_q    <= (fill_q <= sha256_pkg::FillPadMax);
			end
			if (state_q == sha256_pkg::ST_PAD) begin
				pad_first_q <= 1'b0;
				if (fill_q == sha256_pkg::FillLast) begin
					final_q <= len_ok_q;
				end
			end
			if (state_q == sha256_pkg::ST_COMP) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == sha256_pkg::ST_FOLD && pad_q) begin
				// overflow block done: the next block carries the length
				len_ok_q <= 1'b1;
				if (final_q) begin
					pad_q   <= 1'b0;
					final_q <= 1'b0;
				end
			end
			if (digest_valid && digest_ready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == sha256_pkg::WordLast) begin
					count_q <= '0;
					fill_q  <= '0;
				end
			end
		end
	end

	assign word_index = idx_q;
	assign last       = (idx_q == sha256_pkg::WordLast);

	sha256_sched u_sched (
		.clk   (clk),
		.ctrl  (sc),
		.w_cur (w_cur)
	);

	sha256_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (rc),
		.w_cur     (w_cur),
		.sel       (idx_q),
		.hash_word (digest_word)
	);

endmodule

`default_nettype wire

### test/sha256_hash_engine_unit_checker.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit_checker
// Watches both channels of the hash engine, keeps its own SHA-256 chaining
// state and block buffer, and compares every digest word with its prediction.
// ----------------------------------------------------------------------------

module sha256_hash_engine_unit_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	input  wire        req_ready,
	input  wire        kind,
	input  wire [7:0]  data_byte,
	input  wire        digest_valid,
	input  wire        digest_ready,
	input  wire [31:0] digest_word,
	input  wire [2:0]  word_index,
	input  wire        last,
	output int         fail_count,
	output int         digests_pending,
	output int         words_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] PadByte    = 8'h80;
	localparam logic [2:0] FinalIndex = 3'd7;

	localparam logic [31:0] StartWords [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundConst [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	logic [31:0]  chain [0:7];
	logic [7:0]   block_bytes [0:63];
	logic [5:0]   fill;
	logic [63:0]  bit_count;
	digest_beat_t digest_queue [$];

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] schedule_s0(input logic [31:0] x);
		return rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] schedule_s1(input logic [31:0] x);
		return rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_s0(input logic [31:0] x);
		return rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
	endfunction

	function automatic logic [31:0] round_s1(input logic [31:0] x);
		return rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_count < 40) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
		fail_count++;
	endtask

	task automatic restart_chain();
		int i;
		for (i = 0; i < 8; i++) begin
			chain[i] = StartWords[i];
		end
		fill = '0;
		bit_count = '0;
	endtask

	task automatic compress_block();
		logic [31:0] sched [0:63];
		logic [31:0] v [0:7];
		logic [31:0] t1;
		logic [31:0] t2;
		int i;
		for (i = 0; i < 16; i++) begin
			sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
				block_bytes[4*i+2], block_bytes[4*i+3]};
		end
		for (i = 16; i < 64; i++) begin
			sched[i] = schedule_s1(sched[i-2]) + sched[i-7] +
				schedule_s0(sched[i-15]) + sched[i-16];
		end
		for (i = 0; i < 8; i++) begin
			v[i] = chain[i];
		end
		for (i = 0; i < 64; i++) begin
			t1 = v[7] + round_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) +
				RoundConst[i] + sched[i];
			t2 = round_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++) begin
			chain[i] = chain[i] + v[i];
		end
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		block_bytes[fill] = b;
		fill = fill + 6'd1;
		if (fill == 6'd0) begin
			compress_block();
			bit_count = bit_count + 64'd512;
		end
	endtask

	task automatic finish_message();
		logic [63:0] total;
		int pos;
		int i;
		digest_beat_t beat;
		total = bit_count + 64'(fill) * 64'd8;
		pos = fill;
		block_bytes[pos] = PadByte;
		pos++;
		// no room for the length: close this block and pad a fresh one
		if (pos > 56) begin
			while (pos < 64) begin
				block_bytes[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			block_bytes[pos] = 8'h00;
			pos++;
		end
		for (i = 0; i < 8; i++) begin
			block_bytes[56 + i] = total[63 - 8*i -: 8];
		end
		compress_block();
		for (i = 0; i < 8; i++) begin
			beat.word = chain[i];
			beat.index = 3'(i);
			beat.last = (3'(i) == FinalIndex);
			digest_queue.push_back(beat);
		end
		restart_chain();
	endtask

	always @(posedge clk) begin
		digest_beat_t want;
		if (!arst_n) begin
			restart_chain();
			digest_queue.delete();
			fail_count = 0;
			words_checked = 0;
		end else begin
			// outputs first, so a word cannot match a request taken on this edge
			if (digest_valid && digest_ready) begin
				if (digest_queue.size() == 0) begin
					report_mismatch($sformatf("digest word %h index %0d with no finish pending",
						digest_word, word_index));
				end else begin
					want = digest_queue.pop_front();
					if (digest_word !== want.word) begin
						report_mismatch($sformatf("word %0d: digest_word %h, predicted %h",
							want.index, digest_word, want.word));
					end
					if (word_index !== want.index) begin
						report_mismatch($sformatf("word_index %0d, predicted %0d",
							word_index, want.index));
					end
					if (last !== want.last) begin
						report_mismatch($sformatf("word %0d: last %b, predicted %b",
							want.index, last, want.last));
					end
					words_checked++;
				end
			end
			if (req_valid && req_ready) begin
				if (kind == sha256_pkg::KindFinish) begin
					finish_message();
				end else begin
					absorb_byte(data_byte);
				end
			end
		end
		digests_pending = digest_queue.size();
	end

endmodule

### test/sha256_hash_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// sha256_hash_engine_unit_tb
// Feeds byte messages and finish requests to the hash engine with random
// gaps and digest back-pressure; the checker predicts and compares digests.
// ----------------------------------------------------------------------------

module sha256_hash_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 180;
	localparam int IdleLimit   = 2000;
	localparam int TailCycles  = 200;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        req_valid    = 1'b0;
	logic        kind         = 1'b0;
	logic [7:0]  data_byte    = 8'h00;
	logic        digest_ready = 1'b0;
	logic        req_ready;
	logic        digest_valid;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last;

	int fail_count;
	int digests_pending;
	int words_checked;
	int items_sent    = 0;
	int bytes_sent    = 0;
	int finishes_sent = 0;
	int idle_cycles   = 0;
	int ready_hold    = 0;
	bit no_gaps       = 1'b0;

	sha256_hash_engine_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.kind         (kind),
		.data_byte    (data_byte),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last         (last)
	);

	sha256_hash_engine_unit_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.kind            (kind),
		.data_byte       (data_byte),
		.digest_valid    (digest_valid),
		.digest_ready    (digest_ready),
		.digest_word     (digest_word),
		.word_index      (word_index),
		.last            (last),
		.fail_count      (fail_count),
		.digests_pending (digests_pending),
		.words_checked   (words_checked)
	);

	always #10ns clk = ~clk;

	// digest back-pressure: ready bursts, short stalls, now and then a long one
	always @(negedge clk) begin
		int pick;
		if (ready_hold == 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				digest_ready <= 1'b1;
				ready_hold <= $urandom_range(1, 24);
			end else if (pick < 9) begin
				digest_ready <= 1'b0;
				ready_hold <= $urandom_range(1, 3);
			end else begin
				digest_ready <= 1'b0;
				ready_hold <= $urandom_range(8, 40);
			end
		end else begin
			ready_hold <= ready_hold - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (digest_valid && digest_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IdleLimit) begin
				$display("watchdog: nothing accepted for %0d cycles", IdleLimit);
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 55) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_req(input logic k, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			// drop valid and scramble the idle payload
			req_valid <= 1'b0;
			kind <= 1'($urandom);
			data_byte <= 8'($urandom);
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		items_sent++;
		if (k == sha256_pkg::KindFinish) begin
			finishes_sent++;
		end else begin
			bytes_sent++;
		end
	endtask

	task automatic send_message(input int len);
		int i;
		for (i = 0; i < len; i++) begin
			send_req(sha256_pkg::KindData, 8'($urandom));
		end
		send_req(sha256_pkg::KindFinish, 8'($urandom));
	endtask

	task automatic drain_digests();
		@(negedge clk);
		while (digests_pending != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		int first_random;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// empty messages, the finish byte set to all ones and then all zeros
		send_req(sha256_pkg::KindFinish, 8'hff);
		send_req(sha256_pkg::KindFinish, 8'h00);
		send_req(sha256_pkg::KindData, 8'h61);
		send_req(sha256_pkg::KindData, 8'h62);
		send_req(sha256_pkg::KindData, 8'h63);
		send_req(sha256_pkg::KindFinish, 8'h5a);
		// byte extremes and a byte that looks like the pad marker
		send_req(sha256_pkg::KindData, 8'h00);
		send_req(sha256_pkg::KindData, 8'hff);
		send_req(sha256_pkg::KindData, 8'h80);
		send_req(sha256_pkg::KindFinish, 8'ha5);
		// hold off until every digest word is back
		drain_digests();

		first_random = items_sent;
		// length fits beside the pad marker, or spills into a second block
		send_message($urandom_range(55, 57));
		// from one byte short of a full block up to 70 bytes before the finish
		send_message($urandom_range(63, 70));
		while (items_sent - first_random < RandomItems) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				send_message($urandom_range(40, 70));
			end else begin
				send_message($urandom_range(0, 10));
			end
			if ($urandom_range(0, 9) == 0) begin
				drain_digests();
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;

		drain_digests();
		repeat (TailCycles) @(negedge clk);
		$display("run covered %0d message bytes and %0d finish requests", bytes_sent,
			finishes_sent);
		$display("%0d digest words compared, %0d mismatches", words_checked, fail_count);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
